[rtl/cps_pkg.sv]
`default_nettype none

package cps_pkg;

    // Field widths fixed by the item format.
    localparam int COORD_BITS = 8;
    localparam int OCC_BITS   = 7;

    typedef enum logic [1:0] {
        CMD_PUSH  = 2'd0,
        CMD_POP   = 2'd1,
        CMD_TOP   = 2'd2,
        CMD_CHECK = 2'd3
    } t_cmd;

    typedef enum logic [1:0] {
        STAT_OK    = 2'd0,
        STAT_EMPTY = 2'd1,
        STAT_FULL  = 2'd2
    } t_status;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_READ,
        ST_SCAN,
        ST_FINISH
    } t_state;

    typedef struct packed {
        logic [COORD_BITS-1:0] x;
        logic [COORD_BITS-1:0] y;
    } t_pair;

    typedef struct packed {
        t_cmd                  command;
        logic [COORD_BITS-1:0] coord_x;
        logic [COORD_BITS-1:0] coord_y;
    } t_in_item;

    typedef struct packed {
        logic [COORD_BITS-1:0] out_x;
        logic [COORD_BITS-1:0] out_y;
        logic                  not_on_stack;
        t_status               status;
        logic [OCC_BITS-1:0]   occupancy;
    } t_out_item;

    // Controls from the sequencer to the entry store.
    typedef struct packed {
        logic  wr_en;
        logic  rd_en;
        t_pair wr_data;
        t_pair key;
    } t_mem_ctl;

endpackage

`default_nettype wire

[rtl/coordinate_path_stack.sv]
`default_nettype none

// Channel   Direction  Handshake                 Payload
// input     in         i_in_valid / o_in_ready   i_in_item  (command, coord_x, coord_y)
// output    out        o_out_valid / i_out_ready o_out_item (out_x, out_y, not_on_stack,
//                                                            status, occupancy)
//
// Push, and any command that fails or checks an empty stack, goes from transfer to
// FINISH and then frees the input slot; pop and read top pass through READ first,
// because the entry memory has a registered read port. Check reads one stored entry
// per cycle through the single compare unit until a match or the top entry.
// Reset is synchronous, active low, and empties the stack; the entries are not cleared.
// A result waits in the output register; the next item is taken meanwhile, and only
// its own result stalls until the register is free.

module coordinate_path_stack #(
    parameter int STACK_DEPTH = 64
) (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_in_valid,
    output logic                    o_in_ready,
    input  wire cps_pkg::t_in_item  i_in_item,
    output logic                    o_out_valid,
    input  wire logic               i_out_ready,
    output cps_pkg::t_out_item      o_out_item
);

    localparam int ADDR_BITS = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
    localparam int CNT_BITS  = $clog2(STACK_DEPTH + 1);

    cps_pkg::t_mem_ctl    mem_ctl;
    logic [ADDR_BITS-1:0] wr_addr;
    logic [ADDR_BITS-1:0] rd_addr;
    cps_pkg::t_pair       rd_data;
    logic                 match;

    // Sequencer with fill count and output register.
    cps_ctrl #(
        .STACK_DEPTH (STACK_DEPTH),
        .ADDR_BITS   (ADDR_BITS),
        .CNT_BITS    (CNT_BITS)
    ) u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_in_item   (i_in_item),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_item  (o_out_item),
        .o_ctl       (mem_ctl),
        .o_wr_addr   (wr_addr),
        .o_rd_addr   (rd_addr),
        .i_rd_data   (rd_data),
        .i_match     (match)
    );

    // Entry memory and compare unit.
    cps_store #(
        .STACK_DEPTH (STACK_DEPTH),
        .ADDR_BITS   (ADDR_BITS)
    ) u_store (
        .i_clk     (i_clk),
        .i_ctl     (mem_ctl),
        .i_wr_addr (wr_addr),
        .i_rd_addr (rd_addr),
        .o_rd_data (rd_data),
        .o_match   (match)
    );

    // The store is never written and read in the same cycle.
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(mem_ctl.wr_en && mem_ctl.rd_en))
        else $error("entry store written and read together");

    // A refused push reports a full stack.
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && (o_out_item.status == cps_pkg::STAT_FULL) |->
        o_out_item.occupancy == cps_pkg::OCC_BITS'(STACK_DEPTH))
        else $error("full status with wrong occupancy");

    // An empty status carries no coordinates and no entries.
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && (o_out_item.status == cps_pkg::STAT_EMPTY) |->
        (o_out_item.occupancy == '0) && (o_out_item.out_x == '0) &&
        (o_out_item.out_y == '0))
        else $error("empty status with stale data");

    // Absence is only reported with an ok status.
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out_item.not_on_stack |->
        o_out_item.status == cps_pkg::STAT_OK)
        else $error("absent flag with error status");

endmodule

`default_nettype wire

[rtl/cps_store.sv]
`default_nettype none

module cps_store #(
    parameter int STACK_DEPTH = 64,
    parameter int ADDR_BITS   = 6
) (
    input  wire logic                 i_clk,
    input  wire cps_pkg::t_mem_ctl    i_ctl,
    input  wire logic [ADDR_BITS-1:0] i_wr_addr,
    input  wire logic [ADDR_BITS-1:0] i_rd_addr,
    output cps_pkg::t_pair            o_rd_data,
    output logic                      o_match
);

    // Entry memory: one write port and one registered read port.
    cps_pkg::t_pair r_mem [STACK_DEPTH];
    cps_pkg::t_pair r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_ctl.wr_en) begin
            r_mem[i_wr_addr] <= i_ctl.wr_data;
        end
        if (i_ctl.rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    // Shared compare unit: the entry just read against the search key.
    assign o_rd_data = r_rd_data;
    assign o_match   = (r_rd_data == i_ctl.key);

endmodule

`default_nettype wire

[rtl/cps_ctrl.sv]
`default_nettype none

module cps_ctrl #(
    parameter int STACK_DEPTH = 64,
    parameter int ADDR_BITS   = 6,
    parameter int CNT_BITS    = 7
) (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 i_in_valid,
    output logic                      o_in_ready,
    input  wire cps_pkg::t_in_item    i_in_item,
    output logic                      o_out_valid,
    input  wire logic                 i_out_ready,
    output cps_pkg::t_out_item        o_out_item,
    output cps_pkg::t_mem_ctl         o_ctl,
    output logic [ADDR_BITS-1:0]      o_wr_addr,
    output logic [ADDR_BITS-1:0]      o_rd_addr,
    input  wire cps_pkg::t_pair       i_rd_data,
    input  wire logic                 i_match
);

    localparam logic [CNT_BITS-1:0] DEPTH_CNT = CNT_BITS'(STACK_DEPTH);

    cps_pkg::t_state    r_state, n_state;
    logic [CNT_BITS-1:0] r_fill, n_fill;
    logic [ADDR_BITS-1:0] r_idx, n_idx;
    cps_pkg::t_cmd      r_cmd, n_cmd;
    cps_pkg::t_pair     r_key, n_key;
    cps_pkg::t_out_item r_res, n_res;
    logic               r_out_valid, n_out_valid;
    cps_pkg::t_out_item r_out_item, n_out_item;
    logic [CNT_BITS-1:0] idx_next;

    // Control state.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= cps_pkg::ST_IDLE;
            r_fill      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_fill      <= n_fill;
            r_out_valid <= n_out_valid;
        end
    end

    // Payload and scan registers.
    always_ff @(posedge i_clk) begin
        r_idx      <= n_idx;
        r_cmd      <= n_cmd;
        r_key      <= n_key;
        r_res      <= n_res;
        r_out_item <= n_out_item;
    end

    assign idx_next = CNT_BITS'(r_idx) + CNT_BITS'(1);

    // Sequencer: next state, memory controls and result assembly.
    always_comb begin
        n_state     = r_state;
        n_fill      = r_fill;
        n_idx       = r_idx;
        n_cmd       = r_cmd;
        n_key       = r_key;
        n_res       = r_res;
        n_out_valid = r_out_valid;
        n_out_item  = r_out_item;
        o_ctl         = '0;
        o_ctl.key     = r_key;
        o_ctl.wr_data = cps_pkg::t_pair'({i_in_item.coord_x, i_in_item.coord_y});
        o_wr_addr   = ADDR_BITS'(r_fill);
        o_rd_addr   = ADDR_BITS'(idx_next);

        // The output register empties when its transfer completes.
        if (r_out_valid && i_out_ready) begin
            n_out_valid = 1'b0;
        end

        unique case (r_state)
            cps_pkg::ST_IDLE: begin
                if (i_in_valid) begin
                    n_cmd = i_in_item.command;
                    n_key = cps_pkg::t_pair'({i_in_item.coord_x, i_in_item.coord_y});
                    n_res = '0;
                    n_res.status    = cps_pkg::STAT_OK;
                    n_res.occupancy = cps_pkg::OCC_BITS'(r_fill);
                    n_state = cps_pkg::ST_FINISH;
                    unique case (i_in_item.command)
                        cps_pkg::CMD_PUSH: begin
                            if (r_fill == DEPTH_CNT) begin
                                n_res.status = cps_pkg::STAT_FULL;
                            end else begin
                                o_ctl.wr_en     = 1'b1;
                                n_fill          = r_fill + CNT_BITS'(1);
                                n_res.occupancy = cps_pkg::OCC_BITS'(n_fill);
                            end
                        end
                        cps_pkg::CMD_POP, cps_pkg::CMD_TOP: begin
                            if (r_fill == '0) begin
                                n_res.status = cps_pkg::STAT_EMPTY;
                            end else begin
                                o_ctl.rd_en = 1'b1;
                                o_rd_addr   = ADDR_BITS'(r_fill - CNT_BITS'(1));
                                n_state     = cps_pkg::ST_READ;
                            end
                        end
                        cps_pkg::CMD_CHECK: begin
                            if (r_fill == '0) begin
                                n_res.not_on_stack = 1'b1;
                            end else begin
                                o_ctl.rd_en = 1'b1;
                                o_rd_addr   = '0;
                                n_idx       = '0;
                                n_state     = cps_pkg::ST_SCAN;
                            end
                        end
                        default: begin
                            n_state = cps_pkg::ST_FINISH;
                        end
                    endcase
                end
            end
            cps_pkg::ST_READ: begin
                // Top entry has arrived from the store.
                n_res.out_x = i_rd_data.x;
                n_res.out_y = i_rd_data.y;
                if (r_cmd == cps_pkg::CMD_POP) begin
                    n_fill          = r_fill - CNT_BITS'(1);
                    n_res.occupancy = cps_pkg::OCC_BITS'(n_fill);
                end
                n_state = cps_pkg::ST_FINISH;
            end
            cps_pkg::ST_SCAN: begin
                // One stored entry compared per cycle, bottom to top.
                if (i_match) begin
                    n_res.not_on_stack = 1'b0;
                    n_state            = cps_pkg::ST_FINISH;
                end else if (idx_next == r_fill) begin
                    n_res.not_on_stack = 1'b1;
                    n_state            = cps_pkg::ST_FINISH;
                end else begin
                    o_ctl.rd_en = 1'b1;
                    n_idx       = ADDR_BITS'(idx_next);
                end
            end
            cps_pkg::ST_FINISH: begin
                if (!r_out_valid || i_out_ready) begin
                    n_out_item  = r_res;
                    n_out_valid = 1'b1;
                    n_state     = cps_pkg::ST_IDLE;
                end
            end
            default: begin
                n_state = cps_pkg::ST_IDLE;
            end
        endcase
    end

    assign o_in_ready  = (r_state == cps_pkg::ST_IDLE);
    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out_item;

endmodule

`default_nettype wire
